### hdl/ofr_pkg.sv
// Shared types and constants for the page-addressed OLED frame store.
`timescale 1ns / 1ps
`default_nettype none

package ofr_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_DATA_RD
  } state_e;

  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_CMD   = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  localparam int HEAD_SLOTS     = 3;
  localparam int ROWS_PER_PAGE  = 8;

endpackage

`default_nettype wire

### hdl/oled_page_framebuffer_refresh_top.sv
// Top level: frame store memory, pixel read-modify-write and refresh readout sequencer.
//
// Usage: items arrive on the in_* channel (valid/ready) and panel bytes leave on the
// out_* channel (valid/ready). Action 0 draws one pixel, 1 arms a refresh, 2 passes a
// command byte through outside a refresh, 3 is a tick that emits the next refresh byte.
// For each page the readout sends the page command, the two column commands and then
// COLUMNS data bytes; the very last data byte carries last_o.
// Latency: a command or header byte is valid the cycle after its transfer; a data byte
// is read into the frame store read register and then moved to the output register.
// Throughput: an in-range pixel draw (read, then write back of the same byte) and a
// data tick (read) hold off the next item while they use the single frame store port.
// Reset: the frame store is cleared by a pass over all COLUMNS*PAGES bytes (1024 at the
// default size), one byte per cycle, while in_ready_o stays low.
// Stall: one finished byte is held in the output register; while it waits and
// out_ready_i is low, no new item is taken.
`timescale 1ns / 1ps
`default_nettype none

module oled_page_framebuffer_refresh_top
  import ofr_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] pos_x_i,
  input  wire logic [6:0] pos_y_i,
  input  wire logic       color_i,
  input  wire logic [7:0] cmd_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            is_data_o,
  output logic            last_o
);

  localparam int Depth = COLUMNS * PAGES;
  localparam int AddrW = $clog2(Depth);
  localparam int PageW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SlotW = $clog2(COLUMNS + HEAD_SLOTS);
  localparam int Rows  = PAGES * ROWS_PER_PAGE;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(COLUMNS + HEAD_SLOTS - 1);
  localparam logic [SlotW-1:0] FirstData = SlotW'(HEAD_SLOTS);
  localparam logic [PageW-1:0] LastPage = PageW'(PAGES - 1);

  logic [7:0] mem [Depth];
  logic [7:0] rd_q;

  state_e state_q, state_d;

  logic [AddrW-1:0] clr_q;
  logic [AddrW-1:0] addr_q;
  logic [7:0]       mask_q;
  logic             color_q;
  logic             last_pend_q;

  logic             busy_q;
  logic [PageW-1:0] page_q;
  logic [SlotW-1:0] slot_q;

  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             is_data_q;
  logic             last_q;

  logic             acc;
  logic             out_free;
  logic             pix_ok;
  logic             tick_busy;
  logic             tick_data;
  logic             emit_now;
  logic             seq_end_page;
  logic             seq_fin;
  logic [AddrW-1:0] pix_addr;
  logic [AddrW-1:0] data_addr;
  logic [7:0]       head_byte;

  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata;

  assign out_free  = !out_valid_q || out_ready_i;
  assign acc       = in_valid_i && in_ready_o;
  assign pix_ok    = ({1'b0, pos_x_i} < 9'(COLUMNS)) && ({1'b0, pos_y_i} < 8'(Rows));
  assign tick_busy = (action_i == ACT_TICK) && busy_q;
  assign tick_data = tick_busy && (slot_q >= FirstData);
  assign emit_now  = ((action_i == ACT_CMD) && !busy_q) || (tick_busy && !tick_data);
  assign seq_end_page = (slot_q == LastSlot);
  assign seq_fin      = seq_end_page && (page_q == LastPage);

  assign pix_addr  = AddrW'(32'(pos_y_i[6:3]) * COLUMNS + 32'(pos_x_i));
  assign data_addr = AddrW'(32'(page_q) * COLUMNS + 32'(slot_q) - HEAD_SLOTS);

  always_comb begin
    case (slot_q)
      SlotW'(0): head_byte = CMD_PAGE_BASE + 8'(page_q);
      SlotW'(1): head_byte = CMD_COL_LOW;
      default:   head_byte = CMD_COL_HIGH;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastAddr) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc && (action_i == ACT_DRAW) && pix_ok) begin
          state_d = ST_PIX_WR;
        end else if (acc && tick_data) begin
          state_d = ST_DATA_RD;
        end
      end
      ST_PIX_WR:  state_d = ST_IDLE;
      ST_DATA_RD: state_d = ST_IDLE;
      default:    state_d = ST_CLEAR;
    endcase
  end

  // State outputs: handshake and frame store port.
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = addr_q;
    mem_wdata  = 8'h00;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      ST_IDLE: begin
        in_ready_o = out_free;
        mem_addr   = (action_i == ACT_DRAW) ? pix_addr : data_addr;
      end
      ST_PIX_WR: begin
        mem_we    = 1'b1;
        mem_wdata = color_q ? (rd_q | mask_q) : (rd_q & ~mask_q);
      end
      ST_DATA_RD: begin
        mem_addr = addr_q;
      end
      default: begin
        mem_addr = addr_q;
      end
    endcase
  end

  // Single-port frame store; the read returns the old byte in the next cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      addr_q      <= (action_i == ACT_DRAW) ? pix_addr : data_addr;
      mask_q      <= 8'(1) << pos_y_i[2:0];
      color_q     <= color_i;
      last_pend_q <= seq_fin;
    end
  end

  // Refresh sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      page_q <= '0;
      slot_q <= '0;
    end else if (acc) begin
      if ((action_i == ACT_START) && !busy_q) begin
        busy_q <= 1'b1;
        page_q <= '0;
        slot_q <= '0;
      end else if (tick_busy) begin
        if (seq_end_page) begin
          slot_q <= '0;
          if (seq_fin) begin
            page_q <= '0;
            busy_q <= 1'b0;
          end else begin
            page_q <= page_q + PageW'(1);
          end
        end else begin
          slot_q <= slot_q + SlotW'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DATA_RD) || (acc && emit_now)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DATA_RD) begin
      out_byte_q <= rd_q;
      is_data_q  <= 1'b1;
      last_q     <= last_pend_q;
    end else if (acc && emit_now) begin
      out_byte_q <= (action_i == ACT_CMD) ? cmd_byte_i : head_byte;
      is_data_q  <= 1'b0;
      last_q     <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign is_data_o   = is_data_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### hdl/ofr_checker.sv
// Port-level checker for the OLED frame store, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ofr_checker
  import ofr_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [1:0] action_i,
  input wire logic [7:0] pos_x_i,
  input wire logic [6:0] pos_y_i,
  input wire logic       color_i,
  input wire logic [7:0] cmd_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       is_data_o,
  input wire logic       last_o
);

  // A stalled byte holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(is_data_o) && $stable(last_o))
    else $error("stalled output byte changed");

  // The final byte of a refresh is always a data byte.
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> is_data_o)
    else $error("last flag on a command byte");

  // No new item is taken while a finished byte is stuck at the output.
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // A command transfer leaves either nothing or a plain command byte at the output.
  a_cmd_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_CMD)
      |=> !out_valid_o || (!is_data_o && !last_o))
    else $error("command pass-through check failed");

  // Pixel draws never produce output: the output register is empty after one
  // transferred in an otherwise idle cycle.
  a_draw_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == ACT_DRAW) && !out_valid_o |=> !out_valid_o)
    else $error("pixel draw produced an output byte");

endmodule

bind oled_page_framebuffer_refresh_top ofr_checker u_ofr_checker (.*);

`default_nettype wire

### tb/tb_oled_page_framebuffer_refresh_top.sv
// Self-checking testbench for the OLED frame store with its refresh readout sequencer.
`timescale 1ns / 1ps

module tb_oled_page_framebuffer_refresh_top;
  import ofr_pkg::*;

  localparam int COLUMNS        = 128;
  localparam int PAGES          = 8;
  localparam int STORE_BYTES    = COLUMNS * PAGES;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last_flag;
  } panel_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] action;
  logic [7:0] pos_x;
  logic [6:0] pos_y;
  logic       color;
  logic [7:0] cmd_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  // Shadow copy of the panel image and of the readout position.
  logic [7:0]  frame_image [STORE_BYTES];
  bit          readout_busy;
  int          readout_page;
  int          readout_slot;
  panel_byte_t panel_bytes_due [$];

  int error_count;
  int effective_items;
  int send_idle_pct;
  int recv_idle_pct;

  oled_page_framebuffer_refresh_top #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .action_i   (action),
    .pos_x_i    (pos_x),
    .pos_y_i    (pos_y),
    .color_i    (color),
    .cmd_byte_i (cmd_byte),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_byte_o (out_byte),
    .is_data_o  (is_data),
    .last_o     (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advances the shadow image and readout state by one item and queues the byte it sends.
  // Returns 1 unless the block ignores the item.
  function automatic bit predict_panel_byte(logic [1:0] act, logic [7:0] x, logic [6:0] y,
                                            logic c, logic [7:0] cmd);
    panel_byte_t pb;
    int          addr;
    pb = '0;
    case (act)
      ACT_DRAW: begin
        if (x >= COLUMNS || y >= PAGES * ROWS_PER_PAGE) return 1'b0;
        addr = (y / ROWS_PER_PAGE) * COLUMNS + x;
        frame_image[addr][y % ROWS_PER_PAGE] = c;
        return 1'b1;
      end
      ACT_START: begin
        if (readout_busy) return 1'b0;
        readout_busy = 1'b1;
        readout_page = 0;
        readout_slot = 0;
        return 1'b1;
      end
      ACT_CMD: begin
        if (readout_busy) return 1'b0;
        pb.out_byte = cmd;
        panel_bytes_due.push_back(pb);
        return 1'b1;
      end
      default: begin
        if (!readout_busy) return 1'b0;
        if (readout_slot == 0) begin
          pb.out_byte = CMD_PAGE_BASE + 8'(readout_page);
        end else if (readout_slot == 1) begin
          pb.out_byte = CMD_COL_LOW;
        end else if (readout_slot == 2) begin
          pb.out_byte = CMD_COL_HIGH;
        end else begin
          pb.out_byte = frame_image[readout_page * COLUMNS + readout_slot - HEAD_SLOTS];
          pb.is_data  = 1'b1;
        end
        if (readout_slot >= HEAD_SLOTS + COLUMNS - 1) begin
          readout_slot = 0;
          if (readout_page >= PAGES - 1) begin
            readout_page = 0;
            readout_busy = 1'b0;
            pb.last_flag = 1'b1;
          end else begin
            readout_page++;
          end
        end else begin
          readout_slot++;
        end
        panel_bytes_due.push_back(pb);
        return 1'b1;
      end
    endcase
  endfunction

  // Presents one item, holds it until the transfer, then updates the prediction.
  task automatic send_item(input logic [1:0] act, input logic [7:0] x, input logic [6:0] y,
                           input logic c, input logic [7:0] cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    pos_x    <= x;
    pos_y    <= y;
    color    <= c;
    cmd_byte <= cmd;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    effective_items += predict_panel_byte(act, x, y, c, cmd);
  endtask

  // Holds off the sender until every predicted byte has been taken.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (panel_bytes_due.size() != 0);
  endtask

  task automatic test_command_passthrough();
    send_item(ACT_CMD, 8'h00, 7'h00, 1'b0, 8'h00);
    send_item(ACT_CMD, 8'hFF, 7'h7F, 1'b1, 8'hFF);
    send_item(ACT_CMD, 8'h00, 7'h00, 1'b0, 8'hA5);
    send_item(ACT_CMD, 8'h00, 7'h00, 1'b0, 8'h5A);
  endtask

  task automatic test_pixel_bounds();
    send_item(ACT_DRAW, 8'd0,   7'd0,   1'b1, 8'h00);
    send_item(ACT_DRAW, 8'd127, 7'd63,  1'b1, 8'h00);
    send_item(ACT_DRAW, 8'd127, 7'd0,   1'b1, 8'h00);
    send_item(ACT_DRAW, 8'd0,   7'd63,  1'b1, 8'h00);
    send_item(ACT_DRAW, 8'd127, 7'd0,   1'b0, 8'h00);
    // Coordinates past the panel edge must leave the image alone.
    send_item(ACT_DRAW, 8'd128, 7'd5,   1'b1, 8'h00);
    send_item(ACT_DRAW, 8'd5,   7'd64,  1'b1, 8'h00);
    send_item(ACT_DRAW, 8'd255, 7'd127, 1'b1, 8'hFF);
    // A tick with no refresh armed sends nothing.
    send_item(ACT_TICK, 8'h00, 7'h00, 1'b0, 8'h00);
  endtask

  task automatic test_refresh_while_busy();
    send_item(ACT_START, 8'h00, 7'h00, 1'b0, 8'h00);
    send_item(ACT_START, 8'h00, 7'h00, 1'b0, 8'h00);
    send_item(ACT_CMD,   8'h00, 7'h00, 1'b0, 8'h3C);
    repeat (4) send_item(ACT_TICK, 8'h00, 7'h00, 1'b0, 8'h00);
    // Column 1 is still ahead of the readout, column 0 has already gone out.
    send_item(ACT_DRAW, 8'd1, 7'd2, 1'b1, 8'h00);
    send_item(ACT_DRAW, 8'd0, 7'd1, 1'b1, 8'h00);
    repeat (2) send_item(ACT_TICK, 8'h00, 7'h00, 1'b0, 8'h00);
  endtask

  // About half ticks while a readout runs, with draws and stray items mixed in.
  task automatic run_random(input int target);
    int         start_count;
    int         pick;
    logic [1:0] act;
    logic [7:0] x;
    logic [6:0] y;
    start_count = effective_items;
    while (effective_items - start_count < target) begin
      pick = $urandom_range(99);
      if (readout_busy) begin
        act = (pick < 50) ? ACT_TICK : (pick < 94) ? ACT_DRAW : (pick < 97) ? ACT_CMD : ACT_START;
      end else begin
        act = (pick < 30) ? ACT_DRAW : (pick < 55) ? ACT_CMD : (pick < 80) ? ACT_START : ACT_TICK;
      end
      x = 8'($urandom_range(255));
      y = 7'($urandom_range(127));
      if (act == ACT_DRAW && $urandom_range(99) < 85) begin
        x = 8'($urandom_range(COLUMNS - 1));
        y = 7'($urandom_range(PAGES * ROWS_PER_PAGE - 1));
      end
      send_item(act, x, y, 1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  // Runs the readout in flight, or a new one, to its flagged last byte.
  task automatic test_full_readout();
    if (!readout_busy) begin
      send_item(ACT_DRAW, 8'd127, 7'd63, 1'b1, 8'h00);
      send_item(ACT_START, 8'h00, 7'h00, 1'b0, 8'h00);
    end
    while (readout_busy) begin
      if ($urandom_range(9) == 0) begin
        send_item(ACT_DRAW, 8'($urandom_range(COLUMNS - 1)),
                  7'($urandom_range(PAGES * ROWS_PER_PAGE - 1)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
      end else begin
        send_item(ACT_TICK, 8'($urandom_range(255)), 7'($urandom_range(127)),
                  1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (panel_bytes_due.size() == 0) begin
        $error("unexpected panel byte %h (is_data %b, last %b)", out_byte, is_data, last);
        error_count++;
      end else begin
        if (out_byte !== panel_bytes_due[0].out_byte) begin
          $error("out_byte: expected %h, actual %h", panel_bytes_due[0].out_byte, out_byte);
          error_count++;
        end
        if (is_data !== panel_bytes_due[0].is_data) begin
          $error("is_data: expected %b, actual %b", panel_bytes_due[0].is_data, is_data);
          error_count++;
        end
        if (last !== panel_bytes_due[0].last_flag) begin
          $error("last: expected %b, actual %b", panel_bytes_due[0].last_flag, last);
          error_count++;
        end
        void'(panel_bytes_due.pop_front());
      end
    end
  end

  // The reset clearing pass keeps the input side stalled while it clears every byte of
  // the frame store, so the limit sits well above that pass.
  initial begin
    int stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled_cycles = 0;
      else stalled_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    foreach (frame_image[i]) frame_image[i] = 8'h00;
    readout_busy    = 1'b0;
    readout_page    = 0;
    readout_slot    = 0;
    error_count     = 0;
    effective_items = 0;
    send_idle_pct   = 19;
    recv_idle_pct   = 65;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    action   <= ACT_DRAW;
    pos_x    <= '0;
    pos_y    <= '0;
    color    <= 1'b0;
    cmd_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_command_passthrough();
    test_pixel_bounds();
    test_refresh_while_busy();
    wait_for_drain();
    run_random(400);
    wait_for_drain();

    send_idle_pct = 65;
    recv_idle_pct = 19;
    run_random(400);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(400);
    test_full_readout();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && panel_bytes_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ofr_pkg.sv
hdl/oled_page_framebuffer_refresh_top.sv
hdl/ofr_checker.sv
tb/tb_oled_page_framebuffer_refresh_top.sv
